>>> sv/gha_pkg.sv
// Package with shared types and constants for the generational handle allocator.
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  localparam int unsigned IndexBitsDef   = 10;
  localparam int unsigned VersionBitsDef = 8;
  localparam int unsigned HandleW        = 18;
  localparam int unsigned VersionOutW    = 8;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_CLEAR  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_FULL        = 2'd1,
    ST_NOT_ISSUED  = 2'd2,
    ST_STALE       = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_FETCH,
    FSM_EXEC
  } fsm_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_in;    // word accepted: latch it and read both memories
    logic rd_slot;  // read the version of the slot popped from the free list
    logic commit;   // update state and load the result register
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic reuse;    // create that takes its slot from the free list
    logic out_free; // result register can take a new word this cycle
  } stat_t;

endpackage

`default_nettype wire

>>> sv/gha_if.sv
// Valid/ready channel interfaces for command and response words.
`timescale 1ns / 1ps
`default_nettype none

interface gha_cmd_if import gha_pkg::*; ();
  logic                 valid;
  logic                 ready;
  cmd_e                 command;
  logic [HandleW-1:0]   handle_in;

  modport source (output valid, output command, output handle_in, input ready);
  modport sink   (input valid, input command, input handle_in, output ready);
endinterface

interface gha_rsp_if import gha_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [HandleW-1:0]     handle_out;
  logic                   alive;
  logic [VersionOutW-1:0] slot_version;
  status_e                status;

  modport source (output valid, output handle_out, output alive, output slot_version,
                  output status, input ready);
  modport sink   (input valid, input handle_out, input alive, input slot_version,
                  input status, output ready);
endinterface

`default_nettype wire

>>> sv/gha_ctrl.sv
// Controller state machine that sequences memory reads and the commit of each command.
`timescale 1ns / 1ps
`default_nettype none

module gha_ctrl import gha_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire stat_t stat_i,
  output ctrl_t      ctrl_o
);

  fsm_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    ctrl_o     = '0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.rd_in = 1'b1;
          state_d      = FSM_FETCH;
        end
      end
      FSM_FETCH: begin
        // A reused slot needs a second read to fetch its version.
        if (stat_i.reuse) begin
          ctrl_o.rd_slot = 1'b1;
          state_d        = FSM_EXEC;
        end else if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = FSM_IDLE;
        end
      end
      FSM_EXEC: begin
        if (stat_i.out_free) begin
          ctrl_o.commit = 1'b1;
          state_d       = FSM_IDLE;
        end
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/gha_dp.sv
// Datapath with the version memory, the free-list memory, counters and result register.
`timescale 1ns / 1ps
`default_nettype none

module gha_dp import gha_pkg::*; #(
  parameter int unsigned INDEX_BITS   = IndexBitsDef,
  parameter int unsigned VERSION_BITS = VersionBitsDef
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire ctrl_t                  ctrl_i,
  output stat_t                       stat_o,
  input  wire cmd_e                   command_i,
  input  wire logic [HandleW-1:0]     handle_in_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic [HandleW-1:0]          handle_out_o,
  output logic                        alive_o,
  output logic [VersionOutW-1:0]      slot_version_o,
  output status_e                     status_o
);

  localparam int unsigned Slots = 1 << INDEX_BITS;
  localparam int unsigned IB    = INDEX_BITS;
  localparam int unsigned VB    = VERSION_BITS;

  // Version memory entry: queued flag above the version.
  logic [VB:0]   ver_mem  [Slots];
  logic [IB-1:0] fifo_mem [Slots];

  logic [VB:0]   ver_rdata_q;
  logic [IB-1:0] fifo_rdata_q;

  cmd_e          cmd_q;
  logic [IB-1:0] idx_q;
  logic [VB-1:0] ver_q;

  logic [IB:0]   issued_q;
  logic [IB-1:0] head_q;
  logic [IB-1:0] tail_q;
  logic [IB:0]   count_q;

  logic                   out_valid_q;
  logic [HandleW-1:0]     handle_out_q;
  logic                   alive_q;
  logic [VersionOutW-1:0] slot_version_q;
  status_e                status_q;

  logic [IB-1:0]         in_idx;
  logic [VB-1:0]         in_ver;
  logic [HandleW+VB-1:0] in_ext;

  assign in_ext = {{VB{1'b0}}, handle_in_i};
  assign in_idx = handle_in_i[IB-1:0];
  assign in_ver = in_ext[IB +: VB];

  // Commit-time decode.
  logic          st_queued;
  logic [VB-1:0] st_ver;
  logic          not_issued;
  logic          ver_we;
  logic [IB-1:0] ver_waddr;
  logic [VB:0]   ver_wdata;
  logic          fifo_we;
  logic [IB-1:0] new_slot;
  logic [VB-1:0] new_ver;
  logic          new_valid;
  logic [IB:0]   issued_d;
  logic [IB-1:0] head_d;
  logic [IB-1:0] tail_d;
  logic [IB:0]   count_d;
  logic                   alive_d;
  logic [VersionOutW-1:0] slot_version_d;
  status_e                status_d;
  logic [HandleW+IB+VB-1:0] pack_wide;

  assign st_queued  = ver_rdata_q[VB];
  assign st_ver     = ver_rdata_q[VB-1:0];
  assign not_issued = {1'b0, idx_q} >= issued_q;
  assign pack_wide  = {{HandleW{1'b0}}, new_ver, new_slot};

  always_comb begin
    ver_we         = 1'b0;
    ver_waddr      = idx_q;
    ver_wdata      = '0;
    fifo_we        = 1'b0;
    new_slot       = '0;
    new_ver        = '0;
    new_valid      = 1'b0;
    issued_d       = issued_q;
    head_d         = head_q;
    tail_d         = tail_q;
    count_d        = count_q;
    alive_d        = 1'b0;
    slot_version_d = '0;
    status_d       = ST_OK;
    unique case (cmd_q)
      CMD_CREATE: begin
        if (count_q != '0) begin
          new_slot  = fifo_rdata_q;
          new_ver   = st_ver;
          new_valid = 1'b1;
          ver_we    = 1'b1;
          ver_waddr = fifo_rdata_q;
          ver_wdata = {1'b0, st_ver};
          head_d    = head_q + 1'b1;
          count_d   = count_q - 1'b1;
        end else if (!issued_q[IB]) begin
          new_slot  = issued_q[IB-1:0];
          new_valid = 1'b1;
          ver_we    = 1'b1;
          ver_waddr = issued_q[IB-1:0];
          ver_wdata = '0;
          issued_d  = issued_q + 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      CMD_REMOVE: begin
        if (not_issued) begin
          status_d = ST_NOT_ISSUED;
        end else if (st_ver != ver_q || st_queued || count_q[IB]) begin
          status_d = ST_STALE;
        end else begin
          ver_we    = 1'b1;
          ver_waddr = idx_q;
          ver_wdata = {1'b1, st_ver + 1'b1};
          fifo_we   = 1'b1;
          tail_d    = tail_q + 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      CMD_QUERY: begin
        if (not_issued) begin
          status_d = ST_NOT_ISSUED;
        end else begin
          slot_version_d = VersionOutW'(st_ver);
          alive_d        = (st_ver == ver_q);
        end
      end
      CMD_CLEAR: begin
        issued_d = '0;
        head_d   = '0;
        tail_d   = '0;
        count_d  = '0;
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  // Memories: one write port each, registered reads with enable.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && ver_we) begin
      ver_mem[ver_waddr] <= ver_wdata;
    end
    if (ctrl_i.rd_in) begin
      ver_rdata_q <= ver_mem[in_idx];
    end else if (ctrl_i.rd_slot) begin
      ver_rdata_q <= ver_mem[fifo_rdata_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit && fifo_we) begin
      fifo_mem[tail_q] <= idx_q;
    end
    if (ctrl_i.rd_in) begin
      fifo_rdata_q <= fifo_mem[head_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_in) begin
      cmd_q <= command_i;
      idx_q <= in_idx;
      ver_q <= in_ver;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issued_q <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
    end else if (ctrl_i.commit) begin
      issued_q <= issued_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      count_q  <= count_d;
    end
  end

  // Result register decouples the response side from the next command.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.commit) begin
      handle_out_q   <= new_valid ? pack_wide[HandleW-1:0] : '0;
      alive_q        <= alive_d;
      slot_version_q <= slot_version_d;
      status_q       <= status_d;
    end
  end

  assign stat_o.reuse    = (cmd_q == CMD_CREATE) && (count_q != '0);
  assign stat_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign handle_out_o   = handle_out_q;
  assign alive_o        = alive_q;
  assign slot_version_o = slot_version_q;
  assign status_o       = status_q;

endmodule

`default_nettype wire

>>> sv/generational_handle_allocator.sv
// Top level of the generational handle allocator: controller plus datapath.
//
//   Channel   Dir   Word fields
//   cmd_i     in    command, handle_in
//   rsp_o     out   handle_out, alive, slot_version, status
//
// An accepted command reads both memories into registers, then commits its result to
// the output register; a create that reuses a freed slot first rereads the version
// memory at the slot read from the free list (one registered read port each).
// The output register lets a new command be accepted while a response waits.
// A finished command stalls before commit while the previous response is unread.
// Reset needs no clearing pass: the issued counter and free-list count gate memory use.
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator import gha_pkg::*; #(
  parameter int unsigned INDEX_BITS   = IndexBitsDef,
  parameter int unsigned VERSION_BITS = VersionBitsDef
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  gha_cmd_if.sink    cmd_i,
  gha_rsp_if.source  rsp_o
);

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  gha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  gha_dp #(
    .INDEX_BITS   (INDEX_BITS),
    .VERSION_BITS (VERSION_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .command_i      (cmd_i.command),
    .handle_in_i    (cmd_i.handle_in),
    .out_valid_o    (rsp_o.valid),
    .out_ready_i    (rsp_o.ready),
    .handle_out_o   (rsp_o.handle_out),
    .alive_o        (rsp_o.alive),
    .slot_version_o (rsp_o.slot_version),
    .status_o       (rsp_o.status)
  );

  assign cmd_i.ready = in_ready;

endmodule

`default_nettype wire
